// ===== src/sorted_timer_callout_queue_top_macros.svh =====
// assertion macros for the sorted timer callout queue
// used by sorted_timer_callout_queue_top, no other dependencies
`ifndef SORTED_TIMER_CALLOUT_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_CALLOUT_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define STCQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stcq assertion failed");

// next-cycle implication, disabled during reset
`define STCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stcq assertion failed");

`endif

// ===== src/stcq_pkg.sv =====
// shared types and constants of the sorted timer callout queue
// no dependencies
package stcq_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int SLOT_W    = 4;
   localparam int TIME_W    = 32;
   localparam int DATA_W    = 32;
   localparam int INC_W     = 16;

   typedef enum logic [1:0] {
      REQ_ADD  = 2'd0,
      REQ_DEL  = 2'd1,
      REQ_TICK = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RSP_ADD     = 2'd0,
      RSP_DEL     = 2'd1,
      RSP_EXPIRED = 2'd2,
      RSP_DONE    = 2'd3
   } rsp_kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_REMOVE,
      CELL_POP,
      CELL_INSERT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] expiry;
      logic [DATA_W-1:0] data;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type       op;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] expiry;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

   typedef struct packed {
      rsp_kind_type      kind;
      logic              success;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
      logic [TIME_W-1:0] time_now;
      logic              last;
   } rsp_payload_type;

endpackage

// ===== src/stcq_req_if.sv =====
// request channel of the sorted timer callout queue
// field widths from stcq_pkg
interface stcq_req_if;
   import stcq_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [SLOT_W-1:0] timer_slot;
   logic [TIME_W-1:0] expiry_time;
   logic [DATA_W-1:0] user_data;

   modport source (output valid, req_type, timer_slot, expiry_time, user_data,
                   input ready);
   modport sink (input valid, req_type, timer_slot, expiry_time, user_data,
                 output ready);
endinterface

// ===== src/stcq_rsp_if.sv =====
// result channel of the sorted timer callout queue
// field widths from stcq_pkg
interface stcq_rsp_if;
   import stcq_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        result_kind;
   logic              success;
   logic [SLOT_W-1:0] fired_slot;
   logic [DATA_W-1:0] fired_data;
   logic [TIME_W-1:0] time_now;
   logic              last_result;

   modport source (output valid, result_kind, success, fired_slot, fired_data,
                   time_now, last_result, input ready);
   modport sink (input valid, result_kind, success, fired_slot, fired_data,
                 time_now, last_result, output ready);
endinterface

// ===== src/stcq_cell.sv =====
// one queue position of the sorted timer chain
// depends on stcq_pkg
module stcq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  stcq_pkg::cell_cmd_type cmd,
   input  stcq_pkg::entry_type  left_entry,
   input  stcq_pkg::entry_type  right_entry,
   input  logic                 left_later,
   input  logic                 hit_prev,
   output stcq_pkg::entry_type  entry,
   output logic                 later,
   output logic                 hit,
   output logic                 match
);
   import stcq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign match = entry_ff.valid && (entry_ff.slot == cmd.slot);
   // empty positions count as later than any new expiry
   assign later = !entry_ff.valid || (entry_ff.expiry > cmd.expiry);
   assign hit   = hit_prev || (cmd.op == CELL_POP) ||
                  ((cmd.op == CELL_REMOVE) && match);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_REMOVE, CELL_POP: begin
            if (hit) begin
               entry_in = right_entry;
            end
         end
         CELL_INSERT: begin
            if (left_later) begin
               entry_in = left_entry;
            end else if (later) begin
               entry_in.valid  = 1'b1;
               entry_in.slot   = cmd.slot;
               entry_in.expiry = cmd.expiry;
               entry_in.data   = cmd.data;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end
endmodule

// ===== src/stcq_chain.sv =====
// row of queue cells, earliest expiry at position zero
// depends on stcq_pkg and stcq_cell
module stcq_chain #(
   parameter int SLOTS = stcq_pkg::SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stcq_pkg::cell_cmd_type cmd,
   output stcq_pkg::entry_type    head,
   output logic                   found
);
   import stcq_pkg::*;

   entry_type          entries [SLOTS];
   entry_type          left_arr [SLOTS];
   entry_type          right_arr [SLOTS];
   logic [SLOTS-1:0]   later;
   logic [SLOTS-1:0]   hit;
   logic [SLOTS-1:0]   match;
   logic [SLOTS-1:0]   left_later;
   logic [SLOTS-1:0]   hit_prev;

   // neighbor wiring, chain ends see an empty entry
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         left_arr[i]   = (i == 0) ? entry_type'('0) : entries[(i == 0) ? 0 : i - 1];
         right_arr[i]  = (i == SLOTS - 1) ? entry_type'('0)
                                          : entries[(i == SLOTS - 1) ? i : i + 1];
         left_later[i] = (i == 0) ? 1'b0 : later[(i == 0) ? 0 : i - 1];
         hit_prev[i]   = (i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i - 1];
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : gen_cell
      stcq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_arr[g]),
         .right_entry (right_arr[g]),
         .left_later  (left_later[g]),
         .hit_prev    (hit_prev[g]),
         .entry       (entries[g]),
         .later       (later[g]),
         .hit         (hit[g]),
         .match       (match[g])
      );
   end

   assign head  = entries[0];
   assign found = |match;
endmodule

// ===== src/sorted_timer_callout_queue_top.sv =====
// top level of the sorted timer callout queue
// depends on stcq_pkg, stcq_req_if, stcq_rsp_if, stcq_chain and the macros header
//
// usage
//  - req_chan carries one transaction per request: add, delete or tick
//  - rsp_chan returns the results; last_result marks the final one of a request
//  - csr_wr_en/csr_wr_data write the tick increment; users write only while the block is idle (unchecked)
// sequencing
//  - add: answer registered at acceptance; the request channel reopens after the insert step
//    (the accept step takes the slot out of the chain, the insert step inserts it sorted)
//  - delete: answer registered at acceptance; a new request waits for a free result register
//  - tick: advance time, then one result per fired timer plus a tick-done result,
//    with up to SLOTS fired timers; the scan pops the chain head
// reset
//  - synchronous, clears the chain, time to zero, increment to one, no result pending
// stalls
//  - the result register holds while rsp ready is low; the scan and new requests wait
`include "sorted_timer_callout_queue_top_macros.svh"

module sorted_timer_callout_queue_top #(
   parameter int SLOTS = stcq_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   stcq_req_if.sink                   req_chan,
   stcq_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [stcq_pkg::INC_W-1:0] csr_wr_data
);
   import stcq_pkg::*;

   // control and running state
   state_type         state_ff, state_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [INC_W-1:0]  inc_ff;

   // pending insert of an add
   logic [SLOT_W-1:0] ins_slot_ff, ins_slot_in;
   logic [TIME_W-1:0] ins_exp_ff, ins_exp_in;
   logic [DATA_W-1:0] ins_data_ff, ins_data_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              rsp_load;

   cell_cmd_type      cmd;
   entry_type         head;
   logic              found;

   logic              out_free;
   logic              accept;
   logic              slot_ok;
   logic              add_ok;
   logic              head_due;
   logic [TIME_W:0]   time_sum;
   logic [TIME_W-1:0] tick_time;
   req_kind_type      req_kind;

   stcq_chain #(
      .SLOTS (SLOTS)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .head  (head),
      .found (found)
   );

   // result register is free when empty or being drained this cycle
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_kind       = req_kind_type'(req_chan.req_type);

   assign slot_ok = (32'(req_chan.timer_slot) < SLOTS);
   assign add_ok  = slot_ok && (req_chan.expiry_time >= time_ff);

   // saturating time advance
   assign time_sum  = {1'b0, time_ff} + (TIME_W + 1)'(inc_ff);
   assign tick_time = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

   assign head_due = head.valid && (head.expiry <= time_ff);

   always_comb begin
      state_in    = state_ff;
      time_in     = time_ff;
      ins_slot_in = ins_slot_ff;
      ins_exp_in  = ins_exp_ff;
      ins_data_in = ins_data_ff;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      cmd.op      = CELL_HOLD;
      cmd.slot    = req_chan.timer_slot;
      cmd.expiry  = req_chan.expiry_time;
      cmd.data    = req_chan.user_data;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  REQ_ADD: begin
                     rsp_load        = 1'b1;
                     rsp_in.kind     = RSP_ADD;
                     rsp_in.success  = add_ok;
                     rsp_in.slot     = req_chan.timer_slot;
                     rsp_in.data     = '0;
                     rsp_in.time_now = time_ff;
                     rsp_in.last     = 1'b1;
                     if (add_ok) begin
                        // drop any old copy first, insert next cycle
                        cmd.op      = CELL_REMOVE;
                        ins_slot_in = req_chan.timer_slot;
                        ins_exp_in  = req_chan.expiry_time;
                        ins_data_in = req_chan.user_data;
                        state_in    = ST_INSERT;
                     end
                  end
                  REQ_DEL: begin
                     if (slot_ok) begin
                        cmd.op = CELL_REMOVE;
                     end
                     rsp_load        = 1'b1;
                     rsp_in.kind     = RSP_DEL;
                     rsp_in.success  = slot_ok && found;
                     rsp_in.slot     = req_chan.timer_slot;
                     rsp_in.data     = '0;
                     rsp_in.time_now = time_ff;
                     rsp_in.last     = 1'b1;
                  end
                  REQ_TICK: begin
                     time_in  = tick_time;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // unknown request, no result and no state change
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            cmd.op     = CELL_INSERT;
            cmd.slot   = ins_slot_ff;
            cmd.expiry = ins_exp_ff;
            cmd.data   = ins_data_ff;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_in.time_now = time_ff;
               if (head_due) begin
                  // fire the earliest timer and shift the chain up
                  cmd.op         = CELL_POP;
                  rsp_in.kind    = RSP_EXPIRED;
                  rsp_in.success = 1'b1;
                  rsp_in.slot    = head.slot;
                  rsp_in.data    = head.data;
                  rsp_in.last    = 1'b0;
               end else begin
                  rsp_in.kind    = RSP_DONE;
                  rsp_in.success = 1'b0;
                  rsp_in.slot    = '0;
                  rsp_in.data    = '0;
                  rsp_in.last    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         inc_ff       <= INC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            inc_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ins_slot_ff <= ins_slot_in;
      ins_exp_ff  <= ins_exp_in;
      ins_data_ff <= ins_data_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_ff.kind;
   assign rsp_chan.success     = rsp_ff.success;
   assign rsp_chan.fired_slot  = rsp_ff.slot;
   assign rsp_chan.fired_data  = rsp_ff.data;
   assign rsp_chan.time_now    = rsp_ff.time_now;
   assign rsp_chan.last_result = rsp_ff.last;

   // an accepted add or delete is answered next cycle, a tick starts its scan
   `STCQ_ASSERT_NEXT(a_req_answered, clock, reset,
      accept && (req_kind != REQ_NONE), rsp_valid_ff || (state_ff == ST_SCAN))

   // the insert step of an add is always followed by idle in the next cycle
   `STCQ_ASSERT_NEXT(a_insert_one_cycle, clock, reset,
      state_ff == ST_INSERT, state_ff == ST_IDLE)

   // only expired-timer results leave a request open
   `STCQ_ASSERT_IMPL(a_open_only_expired, clock, reset,
      rsp_valid_ff && !rsp_ff.last, rsp_ff.kind == RSP_EXPIRED)

   // a pending result never changes while the receiver stalls
   `STCQ_ASSERT_NEXT(a_rsp_held, clock, reset,
      rsp_valid_ff && !rsp_chan.ready, rsp_valid_ff && $stable(rsp_ff))
endmodule
